### sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/dctg_pkg.sv
// Package for the DRAM command timing gap unit.
// Holds command codes, sizes, sequencer states and timing field helpers.
package dctg_pkg;
    localparam int TimeW = 48;
    localparam int GapW = 10;
    localparam int DefRanks = 2;
    localparam int DefBanks = 8;
    localparam int DefActWindow = 4;
    localparam int Horizon = 1000;
    localparam int GapMax = 1023;
    // Terms are signed and wide enough for a time difference plus small sums.
    localparam int AccW = TimeW + 4;

    typedef logic signed [AccW-1:0] t_acc;

    typedef enum logic [3:0] {
        CMD_ACT = 4'd0, CMD_RDP = 4'd1, CMD_RD = 4'd2, CMD_WRP = 4'd3,
        CMD_WR = 4'd4, CMD_RETIRE = 4'd5, CMD_PRE = 4'd6, CMD_PREALL = 4'd7,
        CMD_ACTALL = 4'd8, CMD_DRIVE = 4'd9, CMD_DATA = 4'd10,
        CMD_RDDRV = 4'd11, CMD_REF = 4'd12, CMD_R13 = 4'd13,
        CMD_R14 = 4'd14, CMD_R15 = 4'd15
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_TERM, ST_DONE, ST_OUT
    } t_state;

    localparam logic [0:0] CfgRow = 1'b0;
    localparam logic [0:0] CfgCol = 1'b1;

    function automatic t_acc fld(input logic [63:0] reg_v, input int idx);
        return t_acc'({44'd0, reg_v[idx*8 +: 8]});
    endfunction

    function automatic t_acc tm(input logic [TimeW-1:0] v);
        return t_acc'({4'd0, v});
    endfunction
endpackage

### sv/dram_command_timing_gap_unit.sv
// DRAM command timing gap unit. Each item (command, rank, bank, posted-CAS flag,
// time) returns the cycles to wait before that command may issue, at least tCMD
// and saturated at 1023. A single shared subtract/compare unit evaluates the
// timing terms. After acceptance the unit scans the other ranks one by one,
// steps through the timing terms, then applies the tCMD floor and records the
// command. The result is then valid. The next item is taken only after the unit
// has returned to idle, so it does not accept a new item while one is in flight.
// Stalling the output holds the result, and a new item is taken only once it
// has left.
module dram_command_timing_gap_unit #(
    parameter int RANKS = dctg_pkg::DefRanks,
    parameter int BANKS = dctg_pkg::DefBanks,
    parameter int ACT_WINDOW = dctg_pkg::DefActWindow
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [3:0]  i_cmd_kind,
    input  logic [0:0]  i_rank_sel,
    input  logic [2:0]  i_bank_sel,
    input  logic        i_posted_cas,
    input  logic [47:0] i_now,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_gap
);
    import dctg_pkg::*;
    localparam int RW = (RANKS > 1) ? $clog2(RANKS) : 1;
    localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int NB = RANKS * BANKS;
    localparam int NBW = (NB > 1) ? $clog2(NB) : 1;
    localparam int HW = (ACT_WINDOW > 1) ? $clog2(ACT_WINDOW) : 1;
    localparam int CW = $clog2(ACT_WINDOW + 1);

    logic [63:0] r_row, r_col;
    logic [TimeW-1:0] r_b_act [NB];
    logic [TimeW-1:0] r_b_pre [NB];
    logic [TimeW-1:0] r_b_rd [NB];
    logic [TimeW-1:0] r_b_wr [NB];
    logic [TimeW-1:0] r_hist [RANKS][ACT_WINDOW];
    logic [CW-1:0] r_cnt [RANKS];
    logic [TimeW-1:0] r_r_ref [RANKS];
    logic [TimeW-1:0] r_r_pre [RANKS];
    logic [TimeW-1:0] r_r_rd [RANKS];
    logic [TimeW-1:0] r_r_wr [RANKS];
    logic [7:0] r_rlen [RANKS];
    logic [7:0] r_wlen [RANKS];

    t_state r_st, n_st;
    logic [3:0] r_step;
    logic r_act;
    t_cmd r_kind;
    logic [RW-1:0] r_r;
    logic [NBW-1:0] r_bi;
    logic r_posted;
    logic [TimeW-1:0] r_now;
    t_acc r_ocas, r_ocasw;
    logic [7:0] r_olen, r_owlen;

    t_acc tRP, tRRD, tRC, tFAW, tRFC, tRCD, tRAS, tAL;
    t_acc tBurst, tCWD, tWTR, tCAS, tRTRS, tRTP, tWR, tCMD, al, rtp;
    t_acc w_base, w_add, w_acc, w_nowa;
    logic w_en, w_clear;
    logic [RW-1:0] w_rin;
    logic [BW-1:0] w_bin;
    logic [CW-1:0] w_c;

    assign tRP = fld(r_row, 0);    assign tRRD = fld(r_row, 1);
    assign tRC = fld(r_row, 2);    assign tFAW = fld(r_row, 3);
    assign tRFC = fld(r_row, 4);   assign tRCD = fld(r_row, 5);
    assign tRAS = fld(r_row, 6);   assign tAL = fld(r_row, 7);
    assign tBurst = fld(r_col, 0); assign tCWD = fld(r_col, 1);
    assign tWTR = fld(r_col, 2);   assign tCAS = fld(r_col, 3);
    assign tRTRS = fld(r_col, 4);  assign tRTP = fld(r_col, 5);
    assign tWR = fld(r_col, 6);    assign tCMD = fld(r_col, 7);
    assign al = r_posted ? tAL : t_acc'(0);
    assign rtp = (tRTP > tCMD) ? (tRTP - tCMD) : t_acc'(0);
    assign w_nowa = tm(r_now);
    assign w_c = r_cnt[r_r];

    // Selector reduction modulo the configured counts. The rank selector is a
    // single bit, so it only folds when there is one rank; the bank selector
    // goes through a small constant table.
    assign w_rin = (RANKS > 1) ? RW'(i_rank_sel) : '0;

    always_comb begin
        w_bin = '0;
        for (int v = 0; v < 8; v++) begin
            if (i_bank_sel == 3'(v)) w_bin = BW'(v % BANKS);
        end
    end

    assign o_stall = (r_st != ST_IDLE);
    assign o_cfg_ready = (r_st == ST_IDLE);
    assign o_valid = (r_st == ST_OUT);

    // The accumulator holds the final maximum while the result waits.
    assign o_gap = (w_acc > t_acc'(GapMax)) ? GapW'(GapMax) : w_acc[GapW-1:0];

    dctg_max_unit u_max (
        .i_clk(i_clk), .i_clear(w_clear), .i_en(w_en),
        .i_base(w_base), .i_now(w_nowa), .i_add(w_add), .o_acc(w_acc)
    );

    // Term sequencer: selects one timestamp and offset per step for the shared unit.
    always_comb begin
        w_base = w_nowa;
        w_add = {1'b1, {(AccW-1){1'b0}}} >>> 1;
        w_en = 1'b0;
        w_clear = (r_st == ST_IDLE);
        if (r_st == ST_TERM) begin
            w_en = 1'b1;
            case (r_kind)
                CMD_ACT: begin
                    case (r_step)
                        4'd0: begin w_base = tm(r_b_pre[r_bi]); w_add = tRP; end
                        4'd1: begin w_base = tm(r_b_act[r_bi]); w_add = tRC; end
                        4'd2: begin w_base = tm(r_r_ref[r_r]); w_add = tRFC; end
                        4'd3: begin
                            w_en = (w_c != '0);
                            w_base = tm(r_hist[r_r][HW'(w_c - CW'(1))]);
                            w_add = tRRD;
                        end
                        4'd4: begin
                            w_en = (32'(w_c) >= ACT_WINDOW);
                            w_base = tm(r_hist[r_r][0]); w_add = tFAW;
                        end
                        default: w_en = 1'b0;
                    endcase
                end
                CMD_RD, CMD_RDP: begin
                    case (r_step)
                        4'd0: begin w_base = tm(r_r_rd[r_r]); w_add = tBurst; end
                        4'd1: begin
                            w_base = tm(r_r_wr[r_r]); w_add = tCWD + tBurst + tWTR;
                        end
                        4'd2: begin w_base = tm(r_b_act[r_bi]); w_add = tRCD - al; end
                        default: w_en = 1'b0;
                    endcase
                end
                CMD_WR, CMD_WRP: begin
                    case (r_step)
                        4'd0: begin w_base = w_nowa; w_add = '0; end
                        4'd1: begin
                            w_base = tm(r_r_rd[r_r]); w_add = tCAS + tBurst + tRTRS - tCWD;
                        end
                        4'd2: begin
                            w_base = r_ocas;
                            w_add = tCAS + t_acc'({44'd0, r_olen}) + tRTRS - tCWD;
                        end
                        4'd3: begin w_base = tm(r_r_wr[r_r]); w_add = tBurst; end
                        4'd4: begin w_base = r_ocasw; w_add = t_acc'({44'd0, r_owlen}); end
                        4'd5: begin w_base = tm(r_b_act[r_bi]); w_add = tRCD - al; end
                        default: w_en = 1'b0;
                    endcase
                end
                CMD_PRE: begin
                    case (r_step)
                        4'd0: begin w_base = w_nowa; w_add = '0; end
                        4'd1: begin
                            w_base = tm(r_b_rd[r_bi]); w_add = al + tCAS + tBurst + rtp;
                        end
                        4'd2: begin
                            w_base = tm(r_b_wr[r_bi]); w_add = al + tCWD + tBurst + tWR;
                        end
                        4'd3: begin w_base = tm(r_b_act[r_bi]); w_add = tRAS; end
                        default: w_en = 1'b0;
                    endcase
                end
                CMD_REF: begin
                    case (r_step)
                        4'd0: begin w_base = tm(r_r_ref[r_r]); w_add = tRFC; end
                        4'd1: begin w_base = tm(r_r_pre[r_r]); w_add = tRP; end
                        default: w_en = 1'b0;
                    endcase
                end
                default: begin w_base = w_nowa; w_add = '0; end
            endcase
        end else if (r_st == ST_DONE) begin
            w_en = 1'b1;
            w_base = w_nowa;
            w_add = tCMD;
        end
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_SCAN;
            ST_SCAN: if (32'(r_step) >= RANKS - 1) n_st = ST_TERM;
            ST_TERM: if (r_step == 4'd5) n_st = ST_DONE;
            ST_DONE: n_st = ST_OUT;
            ST_OUT: if (!i_stall) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_step <= '0;
        end else begin
            r_st <= n_st;
            if (r_st != n_st) r_step <= '0;
            else r_step <= r_step + 4'd1;
        end
    end

    // Item capture and other-rank scan (one rank per cycle).
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_valid) begin
            r_act <= i_action;
            r_kind <= t_cmd'(i_cmd_kind);
            r_r <= w_rin;
            r_bi <= NBW'(32'(w_rin) * BANKS + 32'(w_bin));
            r_posted <= i_posted_cas;
            r_now <= i_now;
            r_ocas <= tm(i_now) - t_acc'(Horizon);
            r_ocasw <= tm(i_now) - t_acc'(Horizon);
            r_olen <= r_col[7:0];
            r_owlen <= r_col[7:0];
        end else if (r_st == ST_SCAN && 32'(r_step) < RANKS) begin
            if (RW'(r_step) != r_r) begin
                if (tm(r_r_rd[RW'(r_step)]) > r_ocas) begin
                    r_ocas <= tm(r_r_rd[RW'(r_step)]);
                    r_olen <= r_rlen[RW'(r_step)];
                end
                if (tm(r_r_wr[RW'(r_step)]) > r_ocasw) begin
                    r_ocasw <= tm(r_r_wr[RW'(r_step)]);
                    r_owlen <= r_wlen[RW'(r_step)];
                end
            end
        end
    end

    // Configuration and recording of issued commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            for (int i = 0; i < NB; i++) begin
                r_b_act[i] <= '0; r_b_pre[i] <= '0; r_b_rd[i] <= '0; r_b_wr[i] <= '0;
            end
            for (int k = 0; k < RANKS; k++) begin
                for (int j = 0; j < ACT_WINDOW; j++) r_hist[k][j] <= '0;
                r_cnt[k] <= '0; r_r_ref[k] <= '0; r_r_pre[k] <= '0;
                r_r_rd[k] <= '0; r_r_wr[k] <= '0; r_rlen[k] <= '0; r_wlen[k] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CfgRow) r_row <= i_cfg_data;
                else r_col <= i_cfg_data;
            end
            if (r_st == ST_DONE && r_act) begin
                case (r_kind)
                    CMD_ACT: begin
                        r_b_act[r_bi] <= r_now;
                        if (32'(w_c) < ACT_WINDOW) begin
                            r_hist[r_r][HW'(w_c)] <= r_now;
                            r_cnt[r_r] <= w_c + CW'(1);
                        end else begin
                            for (int j = 0; j < ACT_WINDOW - 1; j++)
                                r_hist[r_r][j] <= r_hist[r_r][j+1];
                            r_hist[r_r][ACT_WINDOW-1] <= r_now;
                        end
                    end
                    CMD_RD, CMD_RDP: begin
                        r_b_rd[r_bi] <= r_now; r_r_rd[r_r] <= r_now;
                        r_rlen[r_r] <= r_col[7:0];
                    end
                    CMD_WR, CMD_WRP: begin
                        r_b_wr[r_bi] <= r_now; r_r_wr[r_r] <= r_now;
                        r_wlen[r_r] <= r_col[7:0];
                    end
                    CMD_PRE: begin
                        r_b_pre[r_bi] <= r_now; r_r_pre[r_r] <= r_now;
                    end
                    CMD_PREALL: begin
                        for (int i = 0; i < BANKS; i++)
                            r_b_pre[NBW'(32'(r_r) * BANKS + i)] <= r_now;
                        r_r_pre[r_r] <= r_now;
                    end
                    CMD_REF: r_r_ref[r_r] <= r_now;
                    default: ;
                endcase
            end
        end
    end
endmodule

### sv/dctg_max_unit.sv
// Shared max accumulator: adds one enabled term per cycle and keeps the running maximum.
// Depends on dctg_pkg.
module dctg_max_unit (
    input  logic          i_clk,
    input  logic          i_clear,
    input  logic          i_en,
    input  dctg_pkg::t_acc i_base,
    input  dctg_pkg::t_acc i_now,
    input  dctg_pkg::t_acc i_add,
    output dctg_pkg::t_acc o_acc
);
    import dctg_pkg::*;
    t_acc r_acc;
    t_acc w_term;

    // One subtract-add and compare per cycle.
    assign w_term = i_base - i_now + i_add;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= {1'b1, {(AccW-1){1'b0}}};
        end else if (i_en && (w_term > r_acc)) begin
            r_acc <= w_term;
        end
    end
    assign o_acc = r_acc;
endmodule

### sv/dctg_checker.sv
// Port-level checker for the DRAM command timing gap unit, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module dctg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_cfg_ready,
    input logic [9:0] o_gap
);
    // A result held back keeps its value.
    `ASSERT_NEXT(a_gap_hold, o_valid && i_stall, o_valid && $stable(o_gap))
    // No new item while a result waits.
    `ASSERT_IMPL(a_busy_out, o_valid, o_stall)
    // An accepted item blocks further input next cycle.
    `ASSERT_NEXT(a_accept_busy, i_valid && !o_stall, o_stall && !o_valid)
    // Configuration is only taken while idle.
    `ASSERT_IMPL(a_cfg_idle, o_cfg_ready, !o_stall)
endmodule

bind dram_command_timing_gap_unit dctg_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_cfg_ready(o_cfg_ready), .o_gap(o_gap)
);
